### rtl/spcd_pkg.sv
// ----------------------------------------------------------------------------
// spcd_pkg
// shared types and constants of the segment / region crossing detector
// ----------------------------------------------------------------------------
package spcd_pkg;

    localparam int FRAC_BITS       = 8;
    localparam int MAX_VERTICES_DEF = 256;
    localparam int MAX_REGIONS_DEF  = 16;

    // stored coordinate width, wide enough for raw minus offset
    localparam int VCW = (FRAC_BITS > 9) ? (16 + FRAC_BITS) : 25;
    localparam logic [VCW:0] LOAD_OFFSET = (VCW + 1)'(32768) << FRAC_BITS;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [23:0]        vert_x;
        logic [23:0]        vert_z;
        logic               closed_flag;
        logic               has_trigger;
        logic signed [23:0] start_x;
        logic signed [23:0] start_z;
        logic signed [23:0] end_x;
        logic signed [23:0] end_z;
    } t_cmd_item;

    typedef struct packed {
        logic [3:0] region_index;
        logic [8:0] crossing_count;
        logic       last;
        logic       store_overflow;
    } t_result;

    typedef struct packed {
        logic       edge_v;
        logic       reg_end;
        logic       fin;
        logic       trig;
        logic [3:0] idx;
    } t_tag;

    typedef struct packed {
        t_tag                 tag;
        logic signed [VCW-1:0] ax;
        logic signed [VCW-1:0] az;
        logic signed [VCW-1:0] bx;
        logic signed [VCW-1:0] bz;
    } t_tok;

endpackage

### rtl/spcd_area_cell.sv
// ----------------------------------------------------------------------------
// spcd_area_cell
// three-stage sign of the signed area of triangle (p, a, b)
// ----------------------------------------------------------------------------
module spcd_area_cell (
    input  logic                             i_clk,
    input  logic signed [spcd_pkg::VCW-1:0]  i_px,
    input  logic signed [spcd_pkg::VCW-1:0]  i_pz,
    input  logic signed [spcd_pkg::VCW-1:0]  i_ax,
    input  logic signed [spcd_pkg::VCW-1:0]  i_az,
    input  logic signed [spcd_pkg::VCW-1:0]  i_bx,
    input  logic signed [spcd_pkg::VCW-1:0]  i_bz,
    output logic                             o_pos,
    output logic                             o_neg
);
    localparam int W = spcd_pkg::VCW;

    logic signed [W:0]       r_d1, r_d2, r_d3, r_d4;
    logic signed [2*W+1:0]   r_m1, r_m2;
    logic signed [2*W+2:0]   w_diff;

    assign w_diff = {r_m1[2*W+1], r_m1} - {r_m2[2*W+1], r_m2};

    always_ff @(posedge i_clk) begin
        r_d1  <= {i_pz[W-1], i_pz} - {i_az[W-1], i_az};
        r_d2  <= {i_bx[W-1], i_bx} - {i_px[W-1], i_px};
        r_d3  <= {i_px[W-1], i_px} - {i_ax[W-1], i_ax};
        r_d4  <= {i_bz[W-1], i_bz} - {i_pz[W-1], i_pz};
        r_m1  <= r_d1 * r_d2;
        r_m2  <= r_d3 * r_d4;
        o_pos <= (w_diff > 0);
        o_neg <= (w_diff < 0);
    end
endmodule

### rtl/spcd_edge_chain.sv
// ----------------------------------------------------------------------------
// spcd_edge_chain
// edge tokens pass a row of area cells, crossings are counted per region
// ----------------------------------------------------------------------------
module spcd_edge_chain #(
    parameter int CNT_W = 9
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  spcd_pkg::t_tok                   i_tok,
    input  logic signed [spcd_pkg::VCW-1:0]  i_sx,
    input  logic signed [spcd_pkg::VCW-1:0]  i_sz,
    input  logic signed [spcd_pkg::VCW-1:0]  i_ex,
    input  logic signed [spcd_pkg::VCW-1:0]  i_ez,
    input  logic                             i_overflow,
    output logic                             o_res_valid,
    output spcd_pkg::t_result                o_res
);
    spcd_pkg::t_tag r_tag [3];
    logic [3:0]     w_pos, w_neg;
    logic           w_cross;
    logic [CNT_W-1:0] r_cnt, w_cnt;

    spcd_area_cell u_c0 (.i_clk(i_clk), .i_px(i_sx), .i_pz(i_sz),
        .i_ax(i_tok.ax), .i_az(i_tok.az), .i_bx(i_tok.bx), .i_bz(i_tok.bz),
        .o_pos(w_pos[0]), .o_neg(w_neg[0]));
    spcd_area_cell u_c1 (.i_clk(i_clk), .i_px(i_ex), .i_pz(i_ez),
        .i_ax(i_tok.ax), .i_az(i_tok.az), .i_bx(i_tok.bx), .i_bz(i_tok.bz),
        .o_pos(w_pos[1]), .o_neg(w_neg[1]));
    spcd_area_cell u_c2 (.i_clk(i_clk), .i_px(i_tok.ax), .i_pz(i_tok.az),
        .i_ax(i_sx), .i_az(i_sz), .i_bx(i_ex), .i_bz(i_ez),
        .o_pos(w_pos[2]), .o_neg(w_neg[2]));
    spcd_area_cell u_c3 (.i_clk(i_clk), .i_px(i_tok.bx), .i_pz(i_tok.bz),
        .i_ax(i_sx), .i_az(i_sz), .i_bx(i_ex), .i_bz(i_ez),
        .o_pos(w_pos[3]), .o_neg(w_neg[3]));

    assign w_cross = !((w_pos[0] && w_pos[1]) || (w_neg[0] && w_neg[1]) ||
                       (w_pos[2] && w_pos[3]) || (w_neg[2] && w_neg[3]));
    assign w_cnt = (r_tag[2].edge_v && w_cross) ? r_cnt + 1'b1 : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0]    <= '0;
            r_tag[1]    <= '0;
            r_tag[2]    <= '0;
            r_cnt       <= '0;
            o_res_valid <= 1'b0;
        end else begin
            r_tag[0]    <= i_tok.tag;
            r_tag[1]    <= r_tag[0];
            r_tag[2]    <= r_tag[1];
            o_res_valid <= 1'b0;
            if (r_tag[2].fin) begin
                r_cnt       <= '0;
                o_res_valid <= 1'b1;
            end else if (r_tag[2].reg_end) begin
                r_cnt       <= '0;
                o_res_valid <= r_tag[2].trig && (w_cnt != '0);
            end else begin
                r_cnt <= w_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_res.store_overflow <= i_overflow;
        o_res.last           <= r_tag[2].fin;
        o_res.region_index   <= r_tag[2].fin ? 4'd0 : r_tag[2].idx;
        o_res.crossing_count <= r_tag[2].fin ? 9'd0 : 9'(w_cnt);
    end
endmodule

### rtl/segment_polygon_crossing_detector_core.sv
// ----------------------------------------------------------------------------
// segment_polygon_crossing_detector_core
// region table with shared vertex store and a streaming edge crossing test
// ----------------------------------------------------------------------------
// channel   direction  handshake                  payload
// command   in         i_start high, o_busy low   i_cmd  (t_cmd_item)
// result    out        o_res_valid, one cycle     o_res  (t_result)
//
// clear, add vertex and close region leave o_busy low
// a query holds o_busy while it reads the vertex store, one vertex per
// cycle, for the regions inside the box, each framed by the states region,
// tail and close; each region culled or empty passes the region state only;
// then comes the final token and the wait while the cell row drains
// reset is synchronous, active low; the result side cannot stall
// ----------------------------------------------------------------------------
module segment_polygon_crossing_detector_core #(
    parameter int MAX_VERTICES = spcd_pkg::MAX_VERTICES_DEF,
    parameter int MAX_REGIONS  = spcd_pkg::MAX_REGIONS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  spcd_pkg::t_cmd_item i_cmd,
    output logic                o_busy,
    output logic                o_res_valid,
    output spcd_pkg::t_result   o_res
);
    localparam int W   = spcd_pkg::VCW;
    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int VFW = $clog2(MAX_VERTICES + 1);
    localparam int RW  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int RFW = $clog2(MAX_REGIONS + 1);
    localparam logic [VFW-1:0] VMAX = VFW'(MAX_VERTICES);
    localparam logic [RFW-1:0] RMAX = RFW'(MAX_REGIONS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REGION = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_TAIL   = 3'd3;
    localparam logic [2:0] ST_CLOSE  = 3'd4;
    localparam logic [2:0] ST_FINAL  = 3'd5;
    localparam logic [2:0] ST_DRAIN  = 3'd6;

    logic [2:0]     r_state;
    logic [VFW-1:0] r_vfill, r_pend, r_i;
    logic [RFW-1:0] r_rfill;
    logic           r_ovf;
    logic [RW-1:0]  r_ridx;

    logic signed [W-1:0] r_lo_x, r_lo_z, r_hi_x, r_hi_z;
    logic [VFW-1:0]      r_reg_st  [MAX_REGIONS];
    logic [VFW-1:0]      r_reg_len [MAX_REGIONS];
    logic                r_reg_cl  [MAX_REGIONS];
    logic                r_reg_tr  [MAX_REGIONS];
    logic signed [W-1:0] r_reg_lx  [MAX_REGIONS];
    logic signed [W-1:0] r_reg_lz  [MAX_REGIONS];
    logic signed [W-1:0] r_reg_hx  [MAX_REGIONS];
    logic signed [W-1:0] r_reg_hz  [MAX_REGIONS];

    logic [2*W-1:0]      r_mem [MAX_VERTICES];
    logic [2*W-1:0]      r_rd_data;
    logic                r_rd_v, r_rd_first;

    logic signed [W-1:0] r_sx, r_sz, r_ex, r_ez, r_x0, r_x1, r_z0, r_z1;
    logic [VFW-1:0]      r_cur_st, r_cur_len;
    logic                r_cur_cl, r_cur_tr;
    logic signed [W-1:0] r_first_x, r_first_z, r_prev_x, r_prev_z;

    spcd_pkg::t_tok r_tok, n_tok;

    logic                w_acc, w_rd_en;
    logic [AW-1:0]       w_rd_addr;
    logic [VFW-1:0]      w_sum, w_len;
    logic [W:0]          w_tx, w_tz;
    logic signed [W-1:0] w_vx, w_vz, w_sx, w_sz, w_ex, w_ez, w_dx, w_dz;
    logic                w_cull;

    assign o_busy  = (r_state != ST_IDLE);
    assign w_acc   = i_start && !o_busy;
    assign w_tx    = {{(W + 1 - 24){1'b0}}, i_cmd.vert_x} - spcd_pkg::LOAD_OFFSET;
    assign w_tz    = {{(W + 1 - 24){1'b0}}, i_cmd.vert_z} - spcd_pkg::LOAD_OFFSET;
    assign w_vx    = w_tx[W-1:0];
    assign w_vz    = w_tz[W-1:0];
    assign w_sx    = {{(W - 24){i_cmd.start_x[23]}}, i_cmd.start_x};
    assign w_sz    = {{(W - 24){i_cmd.start_z[23]}}, i_cmd.start_z};
    assign w_ex    = {{(W - 24){i_cmd.end_x[23]}}, i_cmd.end_x};
    assign w_ez    = {{(W - 24){i_cmd.end_z[23]}}, i_cmd.end_z};
    assign w_len   = r_vfill - r_pend;
    assign w_sum   = r_cur_st + r_i;
    assign w_rd_addr = w_sum[AW-1:0];
    assign w_rd_en = (r_state == ST_READ);
    assign w_dx    = r_rd_data[2*W-1:W];
    assign w_dz    = r_rd_data[W-1:0];
    assign w_cull  = (r_x1 < r_reg_lx[r_ridx]) || (r_x0 > r_reg_hx[r_ridx]) ||
                     (r_z1 < r_reg_lz[r_ridx]) || (r_z0 > r_reg_hz[r_ridx]);

    always_ff @(posedge i_clk) begin
        if (w_acc && i_cmd.cmd == spcd_pkg::CMD_ADD && r_vfill < VMAX) begin
            r_mem[r_vfill[AW-1:0]] <= {w_vx, w_vz};
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // token into the cell row
    always_comb begin
        n_tok          = '0;
        n_tok.tag.idx  = 4'(r_ridx);
        n_tok.ax       = r_prev_x;
        n_tok.az       = r_prev_z;
        n_tok.bx       = w_dx;
        n_tok.bz       = w_dz;
        if (r_rd_v && !r_rd_first) begin
            n_tok.tag.edge_v = 1'b1;
        end
        case (r_state)
            ST_REGION: begin
                if (w_cull || r_reg_len[r_ridx] == '0) begin
                    n_tok.tag.reg_end = 1'b1;
                end
            end
            ST_CLOSE: begin
                n_tok.tag.reg_end = 1'b1;
                n_tok.tag.edge_v  = r_cur_cl;
                n_tok.tag.trig    = r_cur_tr;
                n_tok.bx          = r_first_x;
                n_tok.bz          = r_first_z;
            end
            ST_FINAL: begin
                n_tok.tag.fin = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_vfill <= '0;
            r_pend  <= '0;
            r_rfill <= '0;
            r_ovf   <= 1'b0;
            r_rd_v  <= 1'b0;
            r_tok   <= '0;
            r_ridx  <= '0;
            r_i     <= '0;
        end else begin
            r_rd_v <= w_rd_en;
            r_tok  <= n_tok;
            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        case (i_cmd.cmd)
                            spcd_pkg::CMD_CLEAR: begin
                                r_vfill <= '0;
                                r_pend  <= '0;
                                r_rfill <= '0;
                                r_ovf   <= 1'b0;
                            end
                            spcd_pkg::CMD_ADD: begin
                                if (r_vfill < VMAX) begin
                                    r_vfill <= r_vfill + 1'b1;
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            spcd_pkg::CMD_CLOSE: begin
                                if (r_rfill >= RMAX) begin
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_rfill <= r_rfill + 1'b1;
                                    r_pend  <= r_vfill;
                                end
                            end
                            default: begin
                                if (r_rfill == '0) begin
                                    r_state <= ST_FINAL;
                                end else begin
                                    r_ridx  <= RW'(r_rfill - 1'b1);
                                    r_state <= ST_REGION;
                                end
                            end
                        endcase
                    end
                end
                ST_REGION: begin
                    if (w_cull || r_reg_len[r_ridx] == '0) begin
                        if (r_ridx == '0) begin
                            r_state <= ST_FINAL;
                        end else begin
                            r_ridx <= r_ridx - 1'b1;
                        end
                    end else begin
                        r_i     <= '0;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (r_i == r_cur_len - 1'b1) begin
                        r_state <= ST_TAIL;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                ST_TAIL: begin
                    r_state <= ST_CLOSE;
                end
                ST_CLOSE: begin
                    if (r_ridx == '0) begin
                        r_state <= ST_FINAL;
                    end else begin
                        r_ridx  <= r_ridx - 1'b1;
                        r_state <= ST_REGION;
                    end
                end
                ST_FINAL: begin
                    r_state <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    if (o_res_valid && o_res.last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc && i_cmd.cmd == spcd_pkg::CMD_ADD && r_vfill < VMAX) begin
            if (r_vfill == r_pend) begin
                r_lo_x <= w_vx;
                r_hi_x <= w_vx;
                r_lo_z <= w_vz;
                r_hi_z <= w_vz;
            end else begin
                if (w_vx < r_lo_x) r_lo_x <= w_vx;
                if (w_vx > r_hi_x) r_hi_x <= w_vx;
                if (w_vz < r_lo_z) r_lo_z <= w_vz;
                if (w_vz > r_hi_z) r_hi_z <= w_vz;
            end
        end
        if (w_acc && i_cmd.cmd == spcd_pkg::CMD_CLOSE && r_rfill < RMAX) begin
            r_reg_st[r_rfill[RW-1:0]]  <= r_pend;
            r_reg_len[r_rfill[RW-1:0]] <= w_len;
            if (w_len == '0) begin
                r_reg_cl[r_rfill[RW-1:0]] <= 1'b0;
                r_reg_tr[r_rfill[RW-1:0]] <= 1'b0;
                r_reg_lx[r_rfill[RW-1:0]] <= '0;
                r_reg_lz[r_rfill[RW-1:0]] <= '0;
                r_reg_hx[r_rfill[RW-1:0]] <= '0;
                r_reg_hz[r_rfill[RW-1:0]] <= '0;
            end else begin
                r_reg_cl[r_rfill[RW-1:0]] <= i_cmd.closed_flag;
                r_reg_tr[r_rfill[RW-1:0]] <= i_cmd.has_trigger;
                r_reg_lx[r_rfill[RW-1:0]] <= r_lo_x;
                r_reg_lz[r_rfill[RW-1:0]] <= r_lo_z;
                r_reg_hx[r_rfill[RW-1:0]] <= r_hi_x;
                r_reg_hz[r_rfill[RW-1:0]] <= r_hi_z;
            end
        end
        if (w_acc && i_cmd.cmd == spcd_pkg::CMD_QUERY) begin
            r_sx <= w_sx;
            r_sz <= w_sz;
            r_ex <= w_ex;
            r_ez <= w_ez;
            r_x0 <= (w_sx < w_ex) ? w_sx : w_ex;
            r_x1 <= (w_sx < w_ex) ? w_ex : w_sx;
            r_z0 <= (w_sz < w_ez) ? w_sz : w_ez;
            r_z1 <= (w_sz < w_ez) ? w_ez : w_sz;
        end
        if (r_state == ST_REGION) begin
            r_cur_st  <= r_reg_st[r_ridx];
            r_cur_len <= r_reg_len[r_ridx];
            r_cur_cl  <= r_reg_cl[r_ridx];
            r_cur_tr  <= r_reg_tr[r_ridx];
        end
        r_rd_first <= (r_i == '0);
        if (r_rd_v) begin
            r_prev_x <= w_dx;
            r_prev_z <= w_dz;
            if (r_rd_first) begin
                r_first_x <= w_dx;
                r_first_z <= w_dz;
            end
        end
    end

    spcd_edge_chain #(
        .CNT_W (VFW)
    ) u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (r_tok),
        .i_sx        (r_sx),
        .i_sz        (r_sz),
        .i_ex        (r_ex),
        .i_ez        (r_ez),
        .i_overflow  (r_ovf),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );
endmodule

### tb/segment_polygon_crossing_detector_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_polygon_crossing_detector_core_test
// self-checking regression of the segment / region crossing detector: vertex
// loads, region closes, clears and query segments are driven through the
// start / busy handshake while a scoreboard predicts the crossing reports
// ----------------------------------------------------------------------------
class crossing_scoreboard;
    localparam int NV = 256;
    localparam int NR = 16;

    longint vx[NV];
    longint vz[NV];
    int     rg_start[NR];
    int     rg_len[NR];
    bit     rg_closed[NR];
    bit     rg_trig[NR];
    longint lo_x[NR], lo_z[NR], hi_x[NR], hi_z[NR];
    int     vfill;
    int     rfill;
    bit     ovf;
    spcd_pkg::t_result expected_q[$];
    int     errors;
    int     checked;
    int     reports;

    function new();
        vfill = 0;
        rfill = 0;
        ovf = 0;
        errors = 0;
        checked = 0;
        reports = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function int area_sign(longint px, longint pz, longint ax, longint az,
                           longint bx, longint bz);
        longint a;
        a = (pz - az) * (bx - px) - (px - ax) * (bz - pz);
        return (a > 0) ? 1 : ((a < 0) ? -1 : 0);
    endfunction

    function void note_item(spcd_pkg::t_cmd_item it);
        longint off, sx, sz, ex, ez, x0, x1, z0, z1, ax, az, bx, bz;
        int ps, len, cnt, b;
        spcd_pkg::t_result r;
        off = longint'(32768) << spcd_pkg::FRAC_BITS;
        case (it.cmd)
            spcd_pkg::CMD_CLEAR: begin
                vfill = 0;
                rfill = 0;
                ovf = 0;
            end
            spcd_pkg::CMD_ADD: begin
                if (vfill < NV) begin
                    vx[vfill] = longint'(it.vert_x) - off;
                    vz[vfill] = longint'(it.vert_z) - off;
                    vfill++;
                end else begin
                    ovf = 1;
                end
            end
            spcd_pkg::CMD_CLOSE: begin
                ps = (rfill == 0) ? 0 : rg_start[rfill-1] + rg_len[rfill-1];
                if (rfill >= NR) begin
                    ovf = 1;
                end else begin
                    len = (vfill > ps) ? vfill - ps : 0;
                    rg_start[rfill] = ps;
                    rg_len[rfill] = len;
                    rg_closed[rfill] = 0;
                    rg_trig[rfill] = 0;
                    lo_x[rfill] = 0; lo_z[rfill] = 0;
                    hi_x[rfill] = 0; hi_z[rfill] = 0;
                    if (len > 0) begin
                        rg_closed[rfill] = it.closed_flag;
                        rg_trig[rfill] = it.has_trigger;
                        lo_x[rfill] = vx[ps]; hi_x[rfill] = vx[ps];
                        lo_z[rfill] = vz[ps]; hi_z[rfill] = vz[ps];
                        for (int i = 1; i < len; i++) begin
                            if (vx[ps+i] < lo_x[rfill]) lo_x[rfill] = vx[ps+i];
                            if (vz[ps+i] < lo_z[rfill]) lo_z[rfill] = vz[ps+i];
                            if (vx[ps+i] > hi_x[rfill]) hi_x[rfill] = vx[ps+i];
                            if (vz[ps+i] > hi_z[rfill]) hi_z[rfill] = vz[ps+i];
                        end
                    end
                    rfill++;
                end
            end
            default: begin
                sx = it.start_x; sz = it.start_z;
                ex = it.end_x;   ez = it.end_z;
                x0 = (sx < ex) ? sx : ex; x1 = (sx < ex) ? ex : sx;
                z0 = (sz < ez) ? sz : ez; z1 = (sz < ez) ? ez : sz;
                for (int k = rfill - 1; k >= 0; k--) begin
                    if (x1 < lo_x[k] || x0 > hi_x[k] || z1 < lo_z[k] || z0 > hi_z[k])
                        continue;
                    cnt = 0;
                    for (int i = 0; i < rg_len[k]; i++) begin
                        if (i == rg_len[k] - 1) begin
                            if (!rg_closed[k]) break;
                            b = rg_start[k];
                        end else begin
                            b = rg_start[k] + i + 1;
                        end
                        ax = vx[rg_start[k]+i]; az = vz[rg_start[k]+i];
                        bx = vx[b]; bz = vz[b];
                        if (area_sign(sx, sz, ax, az, bx, bz) *
                            area_sign(ex, ez, ax, az, bx, bz) > 0) continue;
                        if (area_sign(ax, az, sx, sz, ex, ez) *
                            area_sign(bx, bz, sx, sz, ex, ez) > 0) continue;
                        cnt++;
                    end
                    if (rg_trig[k] && cnt > 0) begin
                        r.region_index = 4'(k);
                        r.crossing_count = 9'(cnt);
                        r.last = 1'b0;
                        r.store_overflow = ovf;
                        expected_q.push_back(r);
                        reports++;
                    end
                end
                r.region_index = '0;
                r.crossing_count = '0;
                r.last = 1'b1;
                r.store_overflow = ovf;
                expected_q.push_back(r);
            end
        endcase
    endfunction

    function void check_result(spcd_pkg::t_result got);
        spcd_pkg::t_result want;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        checked++;
        if (got.region_index !== want.region_index ||
            got.crossing_count !== want.crossing_count ||
            got.last !== want.last || got.store_overflow !== want.store_overflow) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors++;
        end
    endfunction
endclass

module segment_polygon_crossing_detector_core_test;
    localparam longint CYCLE_LIMIT = 1000000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_start = 1'b0;
    spcd_pkg::t_cmd_item i_cmd = '0;
    logic                o_busy;
    logic                o_res_valid;
    spcd_pkg::t_result   o_res;

    crossing_scoreboard sb = new();
    int     gap_pct = 0;
    longint cycles = 0;
    int     sent = 0;

    segment_polygon_crossing_detector_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_cmd(i_cmd),
        .o_busy(o_busy), .o_res_valid(o_res_valid), .o_res(o_res)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("segment_polygon_crossing_detector_core regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) sb.check_result(o_res);
    end

    function automatic int near(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic spcd_pkg::t_cmd_item vertex_at(int ox, int oz);
        spcd_pkg::t_cmd_item it;
        it = '0;
        it.cmd = spcd_pkg::CMD_ADD;
        it.vert_x = 24'(32'h800000 + ox);
        it.vert_z = 24'(32'h800000 + oz);
        it.start_x = 24'($urandom);
        it.end_z = 24'($urandom);
        return it;
    endfunction

    function automatic spcd_pkg::t_cmd_item close_item(bit cl, bit trig);
        spcd_pkg::t_cmd_item it;
        it = '0;
        it.cmd = spcd_pkg::CMD_CLOSE;
        it.closed_flag = cl;
        it.has_trigger = trig;
        return it;
    endfunction

    function automatic spcd_pkg::t_cmd_item query_item(int sx, int sz, int ex, int ez);
        spcd_pkg::t_cmd_item it;
        it = '0;
        it.cmd = spcd_pkg::CMD_QUERY;
        it.start_x = 24'(sx);
        it.start_z = 24'(sz);
        it.end_x = 24'(ex);
        it.end_z = 24'(ez);
        it.vert_x = 24'($urandom);
        return it;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send(spcd_pkg::t_cmd_item it);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_start = 1'b1;
        i_cmd = it;
        do @(posedge i_clk); while (o_busy);
        sb.note_item(it);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_clear();
        spcd_pkg::t_cmd_item it;
        it = '0;
        it.cmd = spcd_pkg::CMD_CLEAR;
        send(it);
    endtask

    task automatic random_query();
        if ($urandom_range(0, 9) == 0)
            send(query_item($urandom, $urandom, $urandom, $urandom));
        else
            send(query_item(near(4000), near(4000), near(4000), near(4000)));
    endtask

    task automatic random_region();
        int n;
        n = $urandom_range(0, 7);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) send(vertex_at($urandom, $urandom));
            else send(vertex_at(near(3000), near(3000)));
        end
        send(close_item(1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0));
    endtask

    task automatic drain();
        i_start = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    initial begin
        spcd_pkg::t_cmd_item noise;
        logic [191:0]        raw;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: empty table, extremes, degenerate regions
        send(query_item(-8388608, -8388608, 8388607, 8388607));
        send(close_item(1'b1, 1'b1));
        send(vertex_at(0, 0));
        send(close_item(1'b1, 1'b1));
        send(vertex_at(256, 256));
        send(close_item(1'b0, 1'b1));
        send(query_item(-512, 0, 512, 0));
        send(query_item(-512, -512, 512, 512));
        send(vertex_at(-8388608, -8388608));
        send(vertex_at(8388607, 8388607));
        send(vertex_at(8388607, -8388608));
        send(close_item(1'b1, 1'b1));
        send(vertex_at(-1000, -1000));
        send(vertex_at(1000, -1000));
        send(vertex_at(1000, 1000));
        send(vertex_at(-1000, 1000));
        send(close_item(1'b1, 1'b0));
        send(query_item(-8388608, 0, 8388607, 0));
        send(query_item(-8388608, -8388608, 8388607, 8388607));
        send(query_item(8388607, 8388607, 8388607, 8388607));
        send_clear();
        // region table overflow
        for (int i = 0; i < 17; i++) send(close_item(1'b1, 1'b1));
        send(query_item(0, 0, 0, 0));
        drain();
        send_clear();

        for (int ph = 0; ph < 3; ph++) begin
            gap_pct = (ph == 0) ? 22 : ((ph == 1) ? 70 : 0);
            for (int i = 0; i < 9; i++) begin
                if (sb.rfill >= 13 && $urandom_range(0, 1) == 0) send_clear();
                case ($urandom_range(0, 9))
                    0: begin
                        raw = {$urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom};
                        noise = raw[$bits(spcd_pkg::t_cmd_item)-1:0];
                        send(noise);
                    end
                    1, 2, 3: random_query();
                    default: begin
                        random_region();
                        repeat ($urandom_range(1, 3)) random_query();
                    end
                endcase
            end
            drain();
        end

        drain();
        $display("sent %0d commands, checked %0d results, %0d crossing reports",
                 sent, sb.checked, sb.reports);
        $display("covered clears, region table overflow, degenerate regions, gaps");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("segment_polygon_crossing_detector_core regression: pass");
        end else begin
            $display("segment_polygon_crossing_detector_core regression: fail");
        end
        $finish;
    end
endmodule
